### hw/rtl/eeuc_pkg.sv
// Package for the earliest expiry unit consumer.
// Holds table sizing constants, the controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package eeuc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int EXP_W       = 32;
    localparam int REM_W       = 16;
    localparam int LIFE_W      = 16;
    localparam int TOT_W       = 32;
    localparam int ENTRY_W     = EXP_W + REM_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_INSERT,
        ST_CONSUME,
        ST_REPORT
    } eeuc_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic insert;
        logic consume;
    } eeuc_cmd_t;

    typedef struct packed {
        logic scan_last;
    } eeuc_status_t;

endpackage

### hw/rtl/eeuc_ram.sv
// Generic simple dual-port RAM with registered read data.
// One write port, one read port; no dependencies.
`timescale 1ns / 1ps

module eeuc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/eeuc_datapath.sv
// Datapath: entry table RAM, valid bits, scan trackers, day counter and total.
// Depends on eeuc_pkg and eeuc_ram.
`timescale 1ns / 1ps

module eeuc_datapath
    import eeuc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [REM_W-1:0]    batch_count,
    input  logic [LIFE_W-1:0]   batch_life,
    input  eeuc_cmd_t           cmd,
    output eeuc_status_t        status,
    output logic                unit_taken,
    output logic [TOT_W-1:0]    total_taken,
    output logic                stock_remains,
    output logic                batch_rejected
);

    logic [EXP_W-1:0]       day_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [REM_W-1:0]       count_reg;
    logic                   has_batch_reg;
    logic [EXP_W-1:0]       exp_new_reg;

    logic [IDX_W-1:0]       scan_idx_reg;
    logic                   pipe_vld_reg;
    logic [IDX_W-1:0]       pipe_idx_reg;

    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic                   best_found_reg;
    logic [EXP_W-1:0]       best_exp_reg;
    logic [REM_W-1:0]       best_rem_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [CNT_W-1:0]       live_cnt_reg;
    logic                   ins_reg;

    logic                   taken_reg;
    logic                   remains_reg;
    logic                   rejected_reg;

    logic [EXP_W-1:0]       next_day;
    logic [EXP_W:0]         exp_sum;
    logic [ENTRY_W-1:0]     rd_data;
    logic [EXP_W-1:0]       rd_exp;
    logic [REM_W-1:0]       rd_rem;
    logic                   rd_alive;
    logic                   best_drop;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;

    assign next_day = (day_reg == {EXP_W{1'b1}}) ? day_reg : day_reg + EXP_W'(1);
    assign exp_sum  = {1'b0, day_reg} + {{(EXP_W + 1 - LIFE_W){1'b0}}, batch_life};

    assign rd_exp   = rd_data[ENTRY_W-1:REM_W];
    assign rd_rem   = rd_data[REM_W-1:0];
    assign rd_alive = valid_reg[pipe_idx_reg] && (rd_exp > day_reg);

    assign best_drop = (best_rem_reg == REM_W'(1));

    assign status.scan_last = (scan_idx_reg == LAST_IDX);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata = {best_exp_reg, best_rem_reg - REM_W'(1)};
        if (cmd.insert)
        begin
            ram_we    = ins_reg;
            ram_waddr = free_idx_reg;
            ram_wdata = {exp_new_reg, count_reg};
        end
        else if (cmd.consume)
        begin
            ram_we = best_found_reg;
        end
    end

    eeuc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg      <= '0;
            total_reg    <= '0;
            valid_reg    <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= cmd.scan;
            if (pipe_vld_reg && valid_reg[pipe_idx_reg] && !rd_alive)
            begin
                valid_reg[pipe_idx_reg] <= 1'b0;
            end
            if (cmd.insert && ins_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.consume)
            begin
                if (best_found_reg && best_drop)
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                end
                if (best_found_reg && (total_reg != {TOT_W{1'b1}}))
                begin
                    total_reg <= total_reg + TOT_W'(1);
                end
                day_reg <= next_day;
            end
        end
    end

    // scan trackers and per-day payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            count_reg      <= batch_count;
            has_batch_reg  <= (batch_count != '0) && (batch_life != '0);
            exp_new_reg    <= exp_sum[EXP_W] ? {EXP_W{1'b1}} : exp_sum[EXP_W-1:0];
            scan_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            live_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                pipe_idx_reg <= scan_idx_reg;
            end
            if (pipe_vld_reg)
            begin
                if (!rd_alive && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= pipe_idx_reg;
                end
                if (rd_alive && (!best_found_reg || (rd_exp < best_exp_reg)))
                begin
                    best_found_reg <= 1'b1;
                    best_exp_reg   <= rd_exp;
                    best_rem_reg   <= rd_rem;
                    best_idx_reg   <= pipe_idx_reg;
                end
                if (rd_alive && (rd_exp > next_day))
                begin
                    live_cnt_reg <= live_cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.decide)
            begin
                ins_reg      <= has_batch_reg && free_found_reg;
                rejected_reg <= has_batch_reg && !free_found_reg;
                if (has_batch_reg && free_found_reg)
                begin
                    if (!best_found_reg || (exp_new_reg < best_exp_reg) ||
                        ((exp_new_reg == best_exp_reg) && (free_idx_reg < best_idx_reg)))
                    begin
                        best_found_reg <= 1'b1;
                        best_exp_reg   <= exp_new_reg;
                        best_rem_reg   <= count_reg;
                        best_idx_reg   <= free_idx_reg;
                    end
                    if (exp_new_reg > next_day)
                    begin
                        live_cnt_reg <= live_cnt_reg + CNT_W'(1);
                    end
                end
            end
            if (cmd.consume)
            begin
                taken_reg <= best_found_reg;
                if (best_found_reg && best_drop && (best_exp_reg > next_day))
                begin
                    remains_reg <= (live_cnt_reg > CNT_W'(1));
                end
                else
                begin
                    remains_reg <= (live_cnt_reg != '0);
                end
            end
        end
    end

    assign unit_taken     = taken_reg;
    assign total_taken    = total_reg;
    assign stock_remains  = remains_reg;
    assign batch_rejected = rejected_reg;

endmodule

### hw/rtl/eeuc_ctrl.sv
// Controller state machine: sequences scan, drain, decide, insert, consume and report.
// Depends on eeuc_pkg.
`timescale 1ns / 1ps

module eeuc_ctrl
    import eeuc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  eeuc_status_t status,
    output eeuc_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    eeuc_state_t state_reg;
    eeuc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_DECIDE;
            ST_DECIDE:  state_next = ST_INSERT;
            ST_INSERT:  state_next = ST_CONSUME;
            ST_CONSUME: state_next = ST_REPORT;
            ST_REPORT:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        busy        = 1'b1;
        done        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:    cmd.scan    = 1'b1;
            ST_DRAIN:   ;
            ST_DECIDE:  cmd.decide  = 1'b1;
            ST_INSERT:  cmd.insert  = 1'b1;
            ST_CONSUME: cmd.consume = 1'b1;
            ST_REPORT:  done        = 1'b1;
            default:    busy        = 1'b1;
        endcase
    end

endmodule

### hw/rtl/earliest_expiry_unit_consumer.sv
// Top level of the earliest expiry unit consumer.
// Depends on eeuc_pkg, eeuc_ctrl and eeuc_datapath.
//
// One day is started by a start pulse while busy is low and ends with the done
// cycle; busy is low again in the cycle after done, so a new day is not accepted
// before then. The main work of a day is the scan of the entry table, which is read
// one entry per cycle from a single RAM read port to expire old batches, find the
// lowest free entry and the earliest expiry.
// Results are valid for exactly the one cycle that done is high and cannot be
// stalled: the receiver must take every transfer as it comes.
`timescale 1ns / 1ps

module earliest_expiry_unit_consumer
    import eeuc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [REM_W-1:0]  batch_count,
    input  logic [LIFE_W-1:0] batch_life,
    output logic              done,
    output logic              unit_taken,
    output logic [TOT_W-1:0]  total_taken,
    output logic              stock_remains,
    output logic              batch_rejected
);

    eeuc_cmd_t    cmd;
    eeuc_status_t status;

    eeuc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    eeuc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .batch_count    (batch_count),
        .batch_life     (batch_life),
        .cmd            (cmd),
        .status         (status),
        .unit_taken     (unit_taken),
        .total_taken    (total_taken),
        .stock_remains  (stock_remains),
        .batch_rejected (batch_rejected)
    );

endmodule

### test/earliest_expiry_unit_consumer_checker.sv
// Checker for the earliest expiry unit consumer: tracks the batch table day by day,
// predicts each day's report and compares it with the transfer the block returns.
// Depends on eeuc_pkg.
`timescale 1ns / 1ps

module earliest_expiry_unit_consumer_checker
    import eeuc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [REM_W-1:0]  batch_count,
    input  logic [LIFE_W-1:0] batch_life,
    input  logic              done,
    input  logic              unit_taken,
    input  logic [TOT_W-1:0]  total_taken,
    input  logic              stock_remains,
    input  logic              batch_rejected,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic             unit_taken;
        logic [TOT_W-1:0] total_taken;
        logic             stock_remains;
        logic             batch_rejected;
    } day_report_t;

    logic [EXP_W-1:0] stock_expiry [TABLE_DEPTH];
    logic [REM_W-1:0] stock_left   [TABLE_DEPTH];
    bit               stock_live   [TABLE_DEPTH];
    logic [EXP_W-1:0] today;
    logic [TOT_W-1:0] eaten_total;
    day_report_t      expected_days [$];
    int               reports_seen;

    initial
    begin
        errors  = 0;
        pending = 0;
        reports_seen = 0;
    end

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic day_report_t predict_day(input logic [REM_W-1:0] cnt,
                                                input logic [LIFE_W-1:0] lif);
        day_report_t      r;
        logic [EXP_W-1:0] next_day;
        int               slot;
        int               best;
        r        = '0;
        next_day = sat_add32(today, 32'd1);
        slot     = -1;
        best     = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (stock_live[i] && stock_expiry[i] <= today)
                stock_live[i] = 1'b0;
        if (cnt != '0 && lif != '0)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot < 0 && !stock_live[i])
                    slot = i;
            if (slot < 0)
                r.batch_rejected = 1'b1;
            else
            begin
                stock_expiry[slot] = sat_add32(today, 32'(lif));
                stock_left[slot]   = cnt;
                stock_live[slot]   = 1'b1;
            end
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (stock_live[i] && (best < 0 || stock_expiry[i] < stock_expiry[best]))
                best = i;
        if (best >= 0)
        begin
            r.unit_taken     = 1'b1;
            stock_left[best] = stock_left[best] - REM_W'(1);
            if (stock_left[best] == '0)
                stock_live[best] = 1'b0;
            eaten_total = sat_add32(eaten_total, 32'd1);
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (stock_live[i] && stock_expiry[i] > next_day)
                r.stock_remains = 1'b1;
        r.total_taken = eaten_total;
        today = next_day;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 200)
            $display("day report %0d: %s got %0h, want %0h", reports_seen, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        day_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                stock_live[i] = 1'b0;
            today       = '0;
            eaten_total = '0;
            expected_days.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_days.size() == 0)
                    report_mismatch("unexpected transfer, total_taken", total_taken, '0);
                else
                begin
                    want = expected_days.pop_front();
                    pending--;
                    if (unit_taken !== want.unit_taken)
                        report_mismatch("unit_taken", 32'(unit_taken),
                                        32'(want.unit_taken));
                    if (total_taken !== want.total_taken)
                        report_mismatch("total_taken", total_taken, want.total_taken);
                    if (stock_remains !== want.stock_remains)
                        report_mismatch("stock_remains", 32'(stock_remains),
                                        32'(want.stock_remains));
                    if (batch_rejected !== want.batch_rejected)
                        report_mismatch("batch_rejected", 32'(batch_rejected),
                                        32'(want.batch_rejected));
                end
                reports_seen++;
            end
            if (start && !busy)
            begin
                expected_days.push_back(predict_day(batch_count, batch_life));
                pending++;
            end
        end
    end

endmodule

### test/earliest_expiry_unit_consumer_test.sv
// Top of the earliest expiry unit consumer testbench: clock, reset, day stimulus,
// watchdog and verdict. Depends on eeuc_pkg, the block and its checker module.
`timescale 1ns / 1ps

module earliest_expiry_unit_consumer_test;

    import eeuc_pkg::*;

    localparam int RANDOM_DAYS    = 1950;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [REM_W-1:0]  batch_count;
    logic [LIFE_W-1:0] batch_life;
    logic              done;
    logic              unit_taken;
    logic [TOT_W-1:0]  total_taken;
    logic              stock_remains;
    logic              batch_rejected;

    int fail_count;
    int pending_days;
    int days_sent;
    int idle_pct;
    int quiet_cycles;

    earliest_expiry_unit_consumer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .batch_count    (batch_count),
        .batch_life     (batch_life),
        .done           (done),
        .unit_taken     (unit_taken),
        .total_taken    (total_taken),
        .stock_remains  (stock_remains),
        .batch_rejected (batch_rejected)
    );

    earliest_expiry_unit_consumer_checker day_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .batch_count    (batch_count),
        .batch_life     (batch_life),
        .done           (done),
        .unit_taken     (unit_taken),
        .total_taken    (total_taken),
        .stock_remains  (stock_remains),
        .batch_rejected (batch_rejected),
        .errors         (fail_count),
        .pending        (pending_days)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // counts cycles with no transfer in either direction
    initial quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send_day(input logic [REM_W-1:0] cnt, input logic [LIFE_W-1:0] lif);
        bit accepted;
        if (days_sent < 660)
            idle_pct = 19;
        else if (days_sent < 1320)
            idle_pct = 76;
        else
            idle_pct = 0;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        batch_count <= cnt;
        batch_life  <= lif;
        do
        begin
            @(posedge clk);
            accepted = !busy;
        end
        while (!accepted);
        days_sent++;
        @(negedge clk);
    endtask

    task automatic empty_batch(output logic [REM_W-1:0] cnt, output logic [LIFE_W-1:0] lif);
        case ($urandom_range(2))
            0:
            begin
                cnt = '0;
                lif = LIFE_W'($urandom);
            end
            1:
            begin
                cnt = REM_W'($urandom);
                lif = '0;
            end
            default:
            begin
                cnt = '0;
                lif = '0;
            end
        endcase
    endtask

    // churn, table fill bursts, empty streaks and full-range noise
    task automatic run_random();
        int                kind;
        int                len;
        int                sent;
        logic [REM_W-1:0]  cnt;
        logic [LIFE_W-1:0] lif;
        sent = 0;
        while (sent < RANDOM_DAYS)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
                len = $urandom_range(40, 10);
            else if (kind < 75)
                len = $urandom_range(90, 64);
            else if (kind < 90)
                len = $urandom_range(30, 5);
            else
                len = $urandom_range(2, 1);
            repeat (len)
            begin
                if (kind < 60)
                begin
                    if ($urandom_range(4) == 0)
                        empty_batch(cnt, lif);
                    else
                    begin
                        cnt = REM_W'($urandom_range(8, 1));
                        lif = LIFE_W'($urandom_range(40, 1));
                    end
                end
                else if (kind < 75)
                begin
                    cnt = REM_W'($urandom_range(65535, 200));
                    lif = LIFE_W'($urandom_range(200, 100));
                end
                else if (kind < 90)
                    empty_batch(cnt, lif);
                else
                begin
                    cnt = REM_W'($urandom);
                    lif = LIFE_W'($urandom);
                end
                send_day(cnt, lif);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        batch_count = '0;
        batch_life  = '0;
        days_sent   = 0;
        idle_pct    = 19;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty days, on an empty table
        send_day(16'd0, 16'd0);
        send_day(16'd0, 16'hFFFF);
        send_day(16'hFFFF, 16'd0);
        // single unit eaten at once, then one that expires the next day
        send_day(16'd1, 16'd1);
        send_day(16'd2, 16'd1);
        send_day(16'd0, 16'd0);
        // equal expiries: lower entry served first
        send_day(16'd4, 16'd6);
        send_day(16'd4, 16'd5);
        send_day(16'd0, 16'd0);
        send_day(16'd0, 16'd0);
        send_day(16'd0, 16'd0);
        // field extremes and bit patterns
        send_day(16'hFFFF, 16'hFFFF);
        send_day(16'h5555, 16'hAAAA);
        send_day(16'hAAAA, 16'h5555);
        send_day(16'd3, 16'd2);
        send_day(16'd1, 16'd3);
        send_day(16'hFFFF, 16'd1);
        send_day(16'd0, 16'd0);
        send_day(16'd0, 16'hFFFF);
        send_day(16'd0, 16'd0);

        run_random();
        start <= 1'b0;

        while (pending_days != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 10) @(posedge clk);

        if (fail_count == 0 && pending_days == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
